/* hw/rtl/oal_pkg.sv */
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and codes for the ordered array list: request operations,
// status codes and the command broadcast to the chain of cells.
// ----------------------------------------------------------------------------
package oal_pkg;

    typedef enum logic [3:0] {
        OP_GET       = 4'd0,
        OP_SET       = 4'd1,
        OP_INS_FIRST = 4'd2,
        OP_INS_AT    = 4'd3,
        OP_INS_LAST  = 4'd4,
        OP_DEL_FIRST = 4'd5,
        OP_DEL_AT    = 4'd6,
        OP_DEL_LAST  = 4'd7,
        OP_SEARCH    = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_NONE,
        K_WRITE,
        K_INSERT,
        K_DELETE,
        K_READ,
        K_SEARCH
    } t_kind;

    typedef struct packed {
        logic  go;
        t_kind kind;
    } t_cell_cmd;

endpackage

/* hw/rtl/oal_cell.sv */
// ----------------------------------------------------------------------------
// oal_cell
// One list entry. Holds its element, takes a new value, its left or right
// neighbor on insert and delete, and registers its read and match results.
// ----------------------------------------------------------------------------
module oal_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7,
    parameter int EW  = 32
) (
    input  logic              i_clk,
    input  oal_pkg::t_cell_cmd i_cmd,
    input  logic [IW-1:0]     i_idx,
    input  logic [CW-1:0]     i_lim,
    input  logic [EW-1:0]     i_val,
    input  logic [EW-1:0]     i_left,
    input  logic [EW-1:0]     i_right,
    output logic [EW-1:0]     o_q,
    output logic [EW-1:0]     o_rd,
    output logic              o_hit
);
    import oal_pkg::*;

    logic [EW-1:0] r_q;
    logic [EW-1:0] n_q;
    logic [EW-1:0] r_rd;
    logic [EW-1:0] n_rd;
    logic          r_hit;
    logic          n_hit;
    logic          at_here;
    logic          above;
    logic          in_list;

    assign at_here = (i_idx == IW'(IDX));
    assign above   = (i_idx < IW'(IDX));
    assign in_list = (CW'(IDX) < i_lim);

    always_comb begin
        n_q   = r_q;
        n_rd  = '0;
        n_hit = 1'b0;
        unique case (i_cmd.kind)
            K_WRITE: begin
                if (at_here) n_q = i_val;
            end
            K_INSERT: begin
                if (at_here) n_q = i_val;
                else if (above) n_q = i_left;
            end
            K_DELETE: begin
                if (at_here || above) n_q = i_right;
            end
            K_READ: begin
                if (at_here) n_rd = r_q;
            end
            K_SEARCH: begin
                n_hit = in_list && (r_q == i_val);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_q   <= n_q;
            r_rd  <= n_rd;
            r_hit <= n_hit;
        end
    end

    assign o_q   = r_q;
    assign o_rd  = r_rd;
    assign o_hit = r_hit;

endmodule

/* hw/rtl/ordered_array_list.sv */
// ----------------------------------------------------------------------------
// ordered_array_list
// Fixed-capacity ordered list built as a chain of cells with an explicit count.
// ----------------------------------------------------------------------------
// Usage: a request word (operation, position, item_value) enters on
// i_valid / o_stall and one result word leaves on o_valid / i_stall for
// every request. Get, set, insert first/at/last, delete first/at/last and
// search are supported; bad requests report a status and change nothing.
// A request passes decode against the count into the command stage, a
// cell step in which every cell shifts, writes, reads or compares its
// entry with the item value, and an OR reduction of the cell results into
// the output register. Throughput is one word per cycle while i_stall is
// low; the count update at decode and the cell step set that figure.
// Reset clears the count and all valid flags; entries are left as they are
// and are never read before being written.
// When the receiver stalls, the output holds and the cell results and the
// decoded command wait in their stages; once both are full o_stall rises.
// ----------------------------------------------------------------------------
module ordered_array_list #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_operation,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_item_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_read_value,
    output logic               o_found,
    output logic [6:0]         o_length_now,
    output logic               o_is_empty,
    output logic [1:0]         o_status
);
    import oal_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int EW   = ELEMENT_WIDTH;

    // count and handshake
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          acc;
    logic          cmd_go;
    logic          cell_go;

    // decode
    t_kind         dec_kind;
    logic [IW-1:0] dec_idx;
    t_status       dec_st;
    logic [CMPW-1:0] pos_c;
    logic [CMPW-1:0] cnt_c;
    logic          full;
    logic          empty;

    // command stage
    logic          r_cmd_v;
    t_kind         r_kind;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_lim;
    logic [EW-1:0] r_val;
    t_status       r_cmd_st;
    logic [CW-1:0] r_cmd_cnt;

    // cell stage
    logic          r_cell_v;
    t_status       r_cell_st;
    logic [CW-1:0] r_cell_cnt;

    // output stage
    logic               r_out_v;
    logic signed [31:0] r_read_value;
    logic               r_found;
    logic [6:0]         r_length_now;
    logic               r_is_empty;
    logic [1:0]         r_status;

    t_cell_cmd          cell_cmd;
    logic [EW-1:0]      cell_q  [CAPACITY];
    logic [EW-1:0]      cell_rd [CAPACITY];
    logic [CAPACITY-1:0] cell_hit;
    logic signed [EW-1:0] rd_or;

    assign cell_go = r_cell_v && (!r_out_v || !i_stall);
    assign cmd_go  = r_cmd_v && (!r_cell_v || cell_go);
    assign o_stall = r_cmd_v && !cmd_go;
    assign acc     = i_valid && !o_stall;

    assign pos_c = CMPW'(i_position);
    assign cnt_c = CMPW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        dec_kind = K_NONE;
        dec_idx  = '0;
        dec_st   = ST_OK;
        n_count  = r_count;
        unique case (i_operation)
            OP_GET: begin
                if (pos_c < cnt_c) begin
                    dec_kind = K_READ;
                    dec_idx  = IW'(i_position);
                end else begin
                    dec_st = ST_RANGE;
                end
            end
            OP_SET: begin
                if (pos_c < cnt_c) begin
                    dec_kind = K_WRITE;
                    dec_idx  = IW'(i_position);
                end else begin
                    dec_st = ST_RANGE;
                end
            end
            OP_INS_FIRST: begin
                if (full) begin
                    dec_st = ST_FULL;
                end else begin
                    dec_kind = K_INSERT;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_INS_AT: begin
                if (full) begin
                    dec_st = ST_FULL;
                end else if (pos_c > cnt_c) begin
                    dec_st = ST_RANGE;
                end else begin
                    dec_kind = K_INSERT;
                    dec_idx  = IW'(i_position);
                    n_count  = r_count + CW'(1);
                end
            end
            OP_INS_LAST: begin
                if (full) begin
                    dec_st = ST_FULL;
                end else begin
                    dec_kind = K_INSERT;
                    dec_idx  = IW'(r_count);
                    n_count  = r_count + CW'(1);
                end
            end
            OP_DEL_FIRST: begin
                if (empty) begin
                    dec_st = ST_EMPTY;
                end else begin
                    dec_kind = K_DELETE;
                    n_count  = r_count - CW'(1);
                end
            end
            OP_DEL_AT: begin
                if (empty) begin
                    dec_st = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    dec_st = ST_RANGE;
                end else begin
                    dec_kind = K_DELETE;
                    dec_idx  = IW'(i_position);
                    n_count  = r_count - CW'(1);
                end
            end
            OP_DEL_LAST: begin
                if (empty) begin
                    dec_st = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_SEARCH: begin
                dec_kind = K_SEARCH;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cmd_v  <= 1'b0;
            r_cell_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (acc) r_count <= n_count;

            if (acc) r_cmd_v <= 1'b1;
            else if (cmd_go) r_cmd_v <= 1'b0;

            if (cmd_go) r_cell_v <= 1'b1;
            else if (cell_go) r_cell_v <= 1'b0;

            if (cell_go) r_out_v <= 1'b1;
            else if (!i_stall) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_kind    <= dec_kind;
            r_idx     <= dec_idx;
            r_lim     <= r_count;
            r_val     <= EW'(i_item_value);
            r_cmd_st  <= dec_st;
            r_cmd_cnt <= n_count;
        end
        if (cmd_go) begin
            r_cell_st  <= r_cmd_st;
            r_cell_cnt <= r_cmd_cnt;
        end
        if (cell_go) begin
            r_read_value <= 32'(rd_or);
            r_found      <= |cell_hit;
            r_length_now <= 7'(r_cell_cnt);
            r_is_empty   <= (r_cell_cnt == '0);
            r_status     <= r_cell_st;
        end
    end

    assign cell_cmd = '{go: cmd_go, kind: r_kind};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [EW-1:0] left_q;
        logic [EW-1:0] right_q;
        if (i == 0) begin : g_first
            assign left_q = r_val;
        end else begin : g_mid_l
            assign left_q = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_q = cell_q[i];
        end else begin : g_mid_r
            assign right_q = cell_q[i+1];
        end
        oal_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW),
            .EW  (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_idx   (r_idx),
            .i_lim   (r_lim),
            .i_val   (r_val),
            .i_left  (left_q),
            .i_right (right_q),
            .o_q     (cell_q[i]),
            .o_rd    (cell_rd[i]),
            .o_hit   (cell_hit[i])
        );
    end

    // only the addressed cell drives a nonzero read word
    for (genvar b = 0; b < EW; b++) begin : g_rd_bit
        logic [CAPACITY-1:0] col;
        for (genvar i = 0; i < CAPACITY; i++) begin : g_col
            assign col[i] = cell_rd[i][b];
        end
        assign rd_or[b] = |col;
    end

    assign o_valid      = r_out_v;
    assign o_read_value = r_read_value;
    assign o_found      = r_found;
    assign o_length_now = r_length_now;
    assign o_is_empty   = r_is_empty;
    assign o_status     = r_status;

endmodule

/* hw/rtl/oal_check.sv */
// ----------------------------------------------------------------------------
// oal_check
// Port-level checks on the result channel of the ordered array list.
// ----------------------------------------------------------------------------
module oal_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_read_value,
    input logic               o_found,
    input logic [6:0]         o_length_now,
    input logic               o_is_empty,
    input logic [1:0]         o_status
);
    import oal_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_length_now == 7'd0)
        else $error("empty flag with nonzero length");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == ST_OK && o_read_value == 32'sd0)
        else $error("found flag on a failed or read word");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_read_value == 32'sd0 && !o_found)
        else $error("rejected word carries data");

endmodule

bind ordered_array_list oal_check u_oal_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_read_value (o_read_value),
    .o_found      (o_found),
    .o_length_now (o_length_now),
    .o_is_empty   (o_is_empty),
    .o_status     (o_status)
);
